@@ rtl/flm_pkg.sv @@
// ----------------------------------------------------------------------------
// flm_pkg
// Shared types and constants of the TVD flux limiter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package flm_pkg;

    // Width of the limiter output: unsigned Q2.16, 0 to 2.0
    localparam int PHI_W = 18;

    // APB data width
    localparam int CFG_DW = 32;

    // Limiter selection register codes
    typedef enum logic [1:0] {
        KIND_MINMOD   = 2'd0,
        KIND_SUPERBEE = 2'd1,
        KIND_VAN_LEER = 2'd2,
        KIND_CHAKRA   = 2'd3
    } t_kind;

    // Side information that travels with an item down the divider chain
    typedef struct packed {
        t_kind kind;
        logic  den_zero;  // denominator was zero
        logic  nonpos;    // ratio is zero or negative
        logic  sat;       // ratio is 2.0 or more
    } t_ctl;

endpackage

`default_nettype wire

@@ rtl/flm_prep.sv @@
// ----------------------------------------------------------------------------
// flm_prep
// Operand front end: magnitudes and signs, then divisor select and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module flm_prep import flm_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire t_kind                 i_kind,
    input  wire logic [DATA_WIDTH-1:0] i_num,
    input  wire logic [DATA_WIDTH-1:0] i_den,
    output logic                       o_valid,
    output t_ctl                       o_ctl,
    output logic [DATA_WIDTH+1:0]      o_rem,
    output logic [DATA_WIDTH+1:0]      o_dv
);

    localparam int DW = DATA_WIDTH;

    // stage A: magnitudes
    logic          r_a_vld;
    t_kind         r_a_kind;
    logic [DW-1:0] r_a_mag_n;
    logic [DW-1:0] r_a_mag_d;
    logic          r_a_neg_n;
    logic          r_a_neg_d;
    logic [DW-1:0] n_mag_n;
    logic [DW-1:0] n_mag_d;

    // stage B: divisor and flags
    logic [DW:0]   n_sum;
    logic [DW:0]   n_den;
    t_ctl          n_ctl;
    logic          r_b_vld;
    t_ctl          r_b_ctl;
    logic [DW+1:0] r_b_rem;
    logic [DW+1:0] r_b_dv;

    always_comb begin
        n_mag_n = i_num[DW-1] ? DW'(~i_num + 1'b1) : i_num;
        n_mag_d = i_den[DW-1] ? DW'(~i_den + 1'b1) : i_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
        end
        r_a_kind  <= i_kind;
        r_a_mag_n <= n_mag_n;
        r_a_mag_d <= n_mag_d;
        r_a_neg_n <= i_num[DW-1];
        r_a_neg_d <= i_den[DW-1];
    end

    // Van Leer divides |n| by |n|+|d|; the others divide |n| by |d|.
    always_comb begin
        n_sum        = {1'b0, r_a_mag_n} + {1'b0, r_a_mag_d};
        n_den        = (r_a_kind == KIND_VAN_LEER) ? n_sum : {1'b0, r_a_mag_d};
        n_ctl.kind     = r_a_kind;
        n_ctl.den_zero = (r_a_mag_d == '0);
        n_ctl.nonpos   = (r_a_mag_n == '0) || (r_a_neg_n != r_a_neg_d);
        n_ctl.sat      = ({1'b0, r_a_mag_n} >= {r_a_mag_d, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_ctl <= n_ctl;
        r_b_rem <= {2'b00, r_a_mag_n};
        r_b_dv  <= {n_den, 1'b0};
    end

    assign o_valid = r_b_vld;
    assign o_ctl   = r_b_ctl;
    assign o_rem   = r_b_rem;
    assign o_dv    = r_b_dv;

endmodule

`default_nettype wire

@@ rtl/flm_cell.sv @@
// ----------------------------------------------------------------------------
// flm_cell
// One restoring-division cell: shift, compare, subtract, one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module flm_cell import flm_pkg::*; #(
    parameter int RW = 34,
    parameter int QW = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_ctl          i_ctl,
    input  wire logic [RW-1:0] i_rem,
    input  wire logic [RW-1:0] i_dv,
    input  wire logic [QW-1:0] i_q,
    output logic               o_valid,
    output t_ctl               o_ctl,
    output logic [RW-1:0]      o_rem,
    output logic [RW-1:0]      o_dv,
    output logic [QW-1:0]      o_q
);

    logic [RW:0]   n_shift;
    logic [RW:0]   n_diff;
    logic          n_bit;
    logic [RW-1:0] n_rem;

    logic          r_vld;
    t_ctl          r_ctl;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_dv;
    logic [QW-1:0] r_q;

    always_comb begin
        n_shift = {i_rem, 1'b0};
        n_diff  = n_shift - {1'b0, i_dv};
        n_bit   = (n_shift >= {1'b0, i_dv});
        n_rem   = n_bit ? n_diff[RW-1:0] : n_shift[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
        r_ctl <= i_ctl;
        r_rem <= n_rem;
        r_dv  <= i_dv;
        r_q   <= {i_q[QW-2:0], n_bit};
    end

    assign o_valid = r_vld;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_dv    = r_dv;
    assign o_q     = r_q;

endmodule

`default_nettype wire

@@ rtl/flm_limit.sv @@
// ----------------------------------------------------------------------------
// flm_limit
// Limiter select on the finished quotient, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module flm_limit import flm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire t_ctl                 i_ctl,
    input  wire logic [FRAC_BITS+1:0] i_q,
    output logic                      o_done,
    output logic [PHI_W-1:0]          o_phi,
    output logic                      o_den_was_zero
);

    localparam int R2W = FRAC_BITS + 3;
    localparam int XW  = (R2W > PHI_W) ? R2W : PHI_W;

    logic [XW-1:0] c_one;
    logic [XW-1:0] c_two;
    logic [XW-1:0] c_four;
    logic [XW-1:0] n_r2;
    logic [XW-1:0] n_r1;
    logic [XW-1:0] n_lo;
    logic [XW-1:0] n_hi;
    logic [XW-1:0] n_phi;

    logic             r_done;
    logic [PHI_W-1:0] r_phi;
    logic             r_zero;

    always_comb begin
        c_one  = XW'(1) << FRAC_BITS;
        c_two  = XW'(2) << FRAC_BITS;
        c_four = XW'(4) << FRAC_BITS;
        // r with one extra fraction bit, saturated at 2.0
        n_r2   = i_ctl.sat ? c_four : XW'(i_q);
        n_r1   = n_r2 >> 1;
        n_lo   = (n_r2 < c_one) ? n_r2 : c_one;
        n_hi   = (n_r1 < c_two) ? n_r1 : c_two;
        case (i_ctl.kind)
            KIND_MINMOD:   n_phi = (n_r1 < c_one) ? n_r1 : c_one;
            KIND_SUPERBEE: n_phi = (n_lo > n_hi) ? n_lo : n_hi;
            KIND_VAN_LEER: n_phi = XW'(i_q);
            KIND_CHAKRA:   n_phi = n_hi;
            default:       n_phi = '0;
        endcase
        if (i_ctl.den_zero || i_ctl.nonpos) begin
            n_phi = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
        r_phi  <= n_phi[PHI_W-1:0];
        r_zero <= i_ctl.den_zero;
    end

    assign o_done         = r_done;
    assign o_phi          = r_phi;
    assign o_den_was_zero = r_zero;

endmodule

`default_nettype wire

@@ rtl/flux_limiter_function.sv @@
// ----------------------------------------------------------------------------
// flux_limiter_function
// TVD flux limiter phi(r), r = numerator / denominator, four selectable kinds.
// ----------------------------------------------------------------------------
// Usage: pulse start with a numerator and denominator pair (signed,
// same fixed-point scale). busy never rises, so an item can be issued in
// every cycle. Each item returns exactly one result, shown on o_phi and
// o_den_was_zero for one cycle while o_done is high; results come back in
// issue order and cannot be stalled. The pipeline is the divider chain:
// one restoring-division cell per quotient bit (FRAC_BITS+2 cells), plus
// two operand stages in front and the limiter register behind.
// limiter_kind (APB offset 0x0) selects minmod, superbee, van Leer or
// chakravarthy; write it only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module flux_limiter_function import flm_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // item channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [DATA_WIDTH-1:0] i_numerator,
    input  wire logic signed [DATA_WIDTH-1:0] i_denominator,
    // result channel
    output logic                              o_done,
    output logic [PHI_W-1:0]                  o_phi,
    output logic                              o_den_was_zero,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [CFG_DW-1:0]            pwdata,
    output logic [CFG_DW-1:0]                 prdata,
    output logic                              pready
);

    localparam int RW = DATA_WIDTH + 2;   // remainder / divisor width
    localparam int QW = FRAC_BITS + 2;    // quotient width
    localparam int NC = FRAC_BITS + 2;    // one cell per quotient bit

    // ------------------------------------------------------------------
    // Configuration: one register, decoded on the word index only
    // ------------------------------------------------------------------
    t_kind r_kind;
    logic  n_cfg_wr;

    assign pready   = 1'b1;
    assign n_cfg_wr = psel && penable && pwrite && pready && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_MINMOD;
        end else if (n_cfg_wr) begin
            r_kind <= t_kind'(pwdata[1:0]);
        end
    end

    assign prdata = paddr[2] ? '0 : {{(CFG_DW-2){1'b0}}, r_kind};

    // Fully pipelined: take an item every cycle
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Operand front end
    // ------------------------------------------------------------------
    logic          s_vld [0:NC];
    t_ctl          s_ctl [0:NC];
    logic [RW-1:0] s_rem [0:NC];
    logic [RW-1:0] s_dv  [0:NC];
    logic [QW-1:0] s_q   [0:NC];

    flm_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_kind  (r_kind),
        .i_num   (i_numerator),
        .i_den   (i_denominator),
        .o_valid (s_vld[0]),
        .o_ctl   (s_ctl[0]),
        .o_rem   (s_rem[0]),
        .o_dv    (s_dv[0])
    );

    assign s_q[0] = '0;

    // ------------------------------------------------------------------
    // Divider chain: each cell resolves one quotient bit, MSB first
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NC; g++) begin : g_cell
        flm_cell #(
            .RW (RW),
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_vld[g]),
            .i_ctl   (s_ctl[g]),
            .i_rem   (s_rem[g]),
            .i_dv    (s_dv[g]),
            .i_q     (s_q[g]),
            .o_valid (s_vld[g+1]),
            .o_ctl   (s_ctl[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_dv    (s_dv[g+1]),
            .o_q     (s_q[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Limiter select and output register
    // ------------------------------------------------------------------
    flm_limit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_limit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_vld[NC]),
        .i_ctl          (s_ctl[NC]),
        .i_q            (s_q[NC]),
        .o_done         (o_done),
        .o_phi          (o_phi),
        .o_den_was_zero (o_den_was_zero)
    );

    // Final remainder is not needed
    logic n_unused_rem;
    assign n_unused_rem = ^s_rem[NC];

endmodule

`default_nettype wire

@@ rtl/flm_check.sv @@
// ----------------------------------------------------------------------------
// flm_check
// Port-level checks of the flux limiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module flm_check import flm_pkg::*; #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic signed [DATA_WIDTH-1:0] i_numerator,
    input wire logic signed [DATA_WIDTH-1:0] i_denominator,
    input wire logic                         o_done,
    input wire logic [PHI_W-1:0]             o_phi,
    input wire logic                         o_den_was_zero,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic [2:0]                   paddr,
    input wire logic [CFG_DW-1:0]            pwdata,
    input wire logic [CFG_DW-1:0]            prdata,
    input wire logic                         pready
);

    localparam int LAT = FRAC_BITS + 5;
    localparam int CW  = $clog2(LAT + 1);

    // cycles since reset, saturating at the pipeline latency
    logic [CW-1:0] r_cnt;
    logic          n_warm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_cnt != CW'(LAT)) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign n_warm = (r_cnt == CW'(LAT));

    // one result per item, a fixed latency later
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_warm |-> (o_done == $past(start && !busy, LAT)))
        else $error("result strobe does not match item issue");

    // a zero denominator is reported on its own result
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_warm && o_done) |->
            (o_den_was_zero == ($past(i_denominator, LAT) == '0)))
        else $error("zero-denominator flag wrong");

    // limiter stays within 0 to 2.0, and zero when the flag is set
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_phi <= (PHI_W'(2) << FRAC_BITS))
                    && (!o_den_was_zero || o_phi == '0)))
        else $error("limiter value out of range");

    // a register write is visible on readback
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && !paddr[2]) |=>
            (paddr[2] || prdata[1:0] == $past(pwdata[1:0])))
        else $error("limiter_kind readback mismatch");

endmodule

bind flux_limiter_function flm_check #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
) u_flm_check (.*);

`default_nettype wire
